// ----- rtl/fct_pkg.sv -----
// Shared constants and types for the frustum culling test unit.
`timescale 1ns / 1ps
package fct_pkg;
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int NORMAL_WIDTH_DEF = 16;
    localparam int EXT_W            = 31;
    localparam int NUM_PLANES       = 6;
    localparam int PIDX_W           = 3;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_POINT  = 2'd1;
    localparam logic [1:0] CMD_SPHERE = 2'd2;
    localparam logic [1:0] CMD_BOX    = 2'd3;

    // Control that travels with an item through the stages.
    typedef struct packed {
        logic [1:0] cmd;
    } t_ctl;
endpackage

// ----- rtl/fct_front.sv -----
// Front end: plane register file, loads, and per-plane distance terms.
`timescale 1ns / 1ps
module fct_front #(
    parameter int CW = fct_pkg::COORD_WIDTH_DEF,
    parameter int NW = fct_pkg::NORMAL_WIDTH_DEF,
    parameter int TW = CW + NW + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [2:0]           i_plane_index,
    input  logic signed [NW-1:0] i_nx,
    input  logic signed [NW-1:0] i_ny,
    input  logic signed [NW-1:0] i_nz,
    input  logic signed [CW-1:0] i_off,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    input  logic signed [CW-1:0] i_cz,
    input  logic [30:0]          i_ex,
    input  logic [30:0]          i_ey,
    input  logic [30:0]          i_ez,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fct_pkg::t_ctl        o_ctl,
    // Per plane: three products, one offset term; the back end sums.
    output logic signed [TW-1:0] o_terms [fct_pkg::NUM_PLANES][4]
);
    import fct_pkg::*;

    logic signed [NW-1:0] r_n [NUM_PLANES][3];
    logic signed [CW-1:0] r_o [NUM_PLANES];
    logic                 r_v;
    t_ctl                 r_ctl;
    logic signed [TW-1:0] r_t [NUM_PLANES][4];
    logic                 take;

    assign o_ready = !r_v || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_v;
    assign o_ctl   = r_ctl;
    assign o_terms = r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_o[p] <= '0;
                for (int k = 0; k < 3; k++) r_n[p][k] <= '0;
            end
        end else begin
            if (take) r_v <= 1'b1;
            else if (i_ready) r_v <= 1'b0;
            if (take && i_cmd == CMD_LOAD && i_plane_index < PIDX_W'(NUM_PLANES)) begin
                r_n[i_plane_index] <= '{i_nx, i_ny, i_nz};
                r_o[i_plane_index] <= i_off;
            end
        end
    end

    // Products are registered here; sums come in the next stage.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ctl.cmd <= i_cmd;
            for (int p = 0; p < NUM_PLANES; p++) begin
                logic signed [NW:0] ax, ay, az;
                logic signed [31:0] hx, hy, hz;
                ax = r_n[p][0] < 0 ? -NW'(0) - {r_n[p][0][NW-1], r_n[p][0]}
                                   : {r_n[p][0][NW-1], r_n[p][0]};
                ay = r_n[p][1] < 0 ? -{r_n[p][1][NW-1], r_n[p][1]}
                                   : {r_n[p][1][NW-1], r_n[p][1]};
                az = r_n[p][2] < 0 ? -{r_n[p][2][NW-1], r_n[p][2]}
                                   : {r_n[p][2][NW-1], r_n[p][2]};
                hx = $signed({1'b0, i_ex >> 1});
                hy = $signed({1'b0, i_ey >> 1});
                hz = $signed({1'b0, i_ez >> 1});
                r_t[p][0] <= TW'(r_n[p][0]) * TW'(i_cx);
                r_t[p][1] <= TW'(r_n[p][1]) * TW'(i_cy);
                r_t[p][2] <= TW'(r_n[p][2]) * TW'(i_cz);
                case (i_cmd)
                    CMD_SPHERE: r_t[p][3] <=
                        (TW'(r_o[p]) + TW'($signed({1'b0, i_ex}))) <<< (NW - 2);
                    CMD_BOX: r_t[p][3] <= (TW'(r_o[p]) <<< (NW - 2))
                        + TW'(ax) * TW'(hx) + TW'(ay) * TW'(hy) + TW'(az) * TW'(hz);
                    default: r_t[p][3] <= TW'(r_o[p]) <<< (NW - 2);
                endcase
            end
        end
    end
endmodule

// ----- rtl/fct_back.sv -----
// Back end: per-plane sums, sign test and the result register.
`timescale 1ns / 1ps
module fct_back #(
    parameter int TW = 52
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fct_pkg::t_ctl        i_ctl,
    input  logic signed [TW-1:0] i_terms [fct_pkg::NUM_PLANES][4],
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_visible
);
    import fct_pkg::*;

    logic r_v;
    logic r_vis;
    logic n_vis;

    always_comb begin
        n_vis = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
            logic signed [TW-1:0] s;
            s = i_terms[p][0] + i_terms[p][1] + i_terms[p][2] + i_terms[p][3];
            if (s[TW-1]) n_vis = 1'b0;
        end
        if (i_ctl.cmd == CMD_LOAD) n_vis = 1'b0;
    end

    assign o_ready   = !r_v || i_ready;
    assign o_valid   = r_v;
    assign o_visible = r_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= 1'b0;
        else if (o_ready) r_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_vis <= n_vis;
    end
endmodule

// ----- rtl/frustum_culling_test_unit.sv -----
// Top level of the six-plane frustum culling test unit.
// Products are formed and registered in the front stage, then summed,
// sign-tested and registered in the back stage, which drives o_visible.
// One item per cycle while the receiver does not stall.
// Reset (synchronous, active low) clears all planes to zero and empties both
// stages; with zero planes every test reports visible.
`timescale 1ns / 1ps
module frustum_culling_test_unit #(
    parameter int COORD_WIDTH  = fct_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_WIDTH = fct_pkg::NORMAL_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [2:0]                    i_plane_index,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_x,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_y,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal_z,
    input  logic signed [COORD_WIDTH-1:0] i_plane_offset,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_center_z,
    input  logic [30:0]                   i_extent_x,
    input  logic [30:0]                   i_extent_y,
    input  logic [30:0]                   i_extent_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_visible
);
    import fct_pkg::*;

    // Distances carry the offset scaled by the normal fraction plus three
    // products; four guard bits keep the sum exact. Box terms grow with the
    // extent width, so the wider of coordinate and extent sets the size.
    localparam int TW = (COORD_WIDTH > EXT_W ? COORD_WIDTH : EXT_W) + NORMAL_WIDTH + 4;

    logic                 mid_valid, mid_ready;
    t_ctl                 mid_ctl;
    logic signed [TW-1:0] mid_terms [NUM_PLANES][4];

    fct_front #(.CW(COORD_WIDTH), .NW(NORMAL_WIDTH), .TW(TW)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_cmd, .i_plane_index,
        .i_nx(i_normal_x), .i_ny(i_normal_y), .i_nz(i_normal_z),
        .i_off(i_plane_offset),
        .i_cx(i_center_x), .i_cy(i_center_y), .i_cz(i_center_z),
        .i_ex(i_extent_x), .i_ey(i_extent_y), .i_ez(i_extent_z),
        .o_valid(mid_valid), .i_ready(mid_ready),
        .o_ctl(mid_ctl), .o_terms(mid_terms)
    );

    fct_back #(.TW(TW)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(mid_valid), .o_ready(mid_ready),
        .i_ctl(mid_ctl), .i_terms(mid_terms),
        .o_valid, .i_ready, .o_visible
    );

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_visible))
        else $error("result changed while stalled");
    // A load never reports visible.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_valid && mid_ready && mid_ctl.cmd == CMD_LOAD |=> !o_visible)
        else $error("load reported visible");
    // Middle stage hands on an item only when the back end takes it.
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_valid && !mid_ready |=> mid_valid)
        else $error("middle item lost");
endmodule

// ----- verif/tb_frustum_culling_test_unit.sv -----
// Self-checking testbench for the six-plane frustum culling test unit.
`timescale 1ns / 1ps
module tb_frustum_culling_test_unit;
    import fct_pkg::*;

    localparam int CW = 32;
    localparam int NW = 16;
    localparam int NORM_SHIFT = NW - 2;

    // Scoreboard: keeps its own copy of the plane store, predicts the visible
    // flag for every accepted item and checks results in order.
    class cull_scoreboard;
        logic signed [NW-1:0] nrm [NUM_PLANES][3];
        logic signed [CW-1:0] ofs [NUM_PLANES];
        bit vis_q[$];
        int errors;

        function new();
            for (int p = 0; p < NUM_PLANES; p++) begin
                for (int k = 0; k < 3; k++) nrm[p][k] = '0;
                ofs[p] = '0;
            end
            errors = 0;
        endfunction

        // Predicts the result of one item and updates the plane store.
        function void note_item(logic [1:0] cmd, logic [2:0] idx,
                                logic signed [NW-1:0] nx, logic signed [NW-1:0] ny,
                                logic signed [NW-1:0] nz, logic signed [CW-1:0] po,
                                logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                logic signed [CW-1:0] cz, logic [30:0] ex,
                                logic [30:0] ey, logic [30:0] ez);
            logic signed [127:0] d;
            logic signed [127:0] an [3];
            bit vis;
            vis = 1'b1;
            if (cmd == CMD_LOAD) begin
                if (idx < NUM_PLANES) begin
                    nrm[idx][0] = nx;
                    nrm[idx][1] = ny;
                    nrm[idx][2] = nz;
                    ofs[idx] = po;
                end
                vis_q.push_back(1'b0);
                return;
            end
            for (int p = 0; p < NUM_PLANES; p++) begin
                d = (128'(ofs[p]) <<< NORM_SHIFT) + 128'(nrm[p][0]) * 128'(cx)
                    + 128'(nrm[p][1]) * 128'(cy) + 128'(nrm[p][2]) * 128'(cz);
                if (cmd == CMD_SPHERE) begin
                    d = d + (128'($signed({1'b0, ex})) <<< NORM_SHIFT);
                end else if (cmd == CMD_BOX) begin
                    for (int k = 0; k < 3; k++) begin
                        an[k] = 128'(nrm[p][k]);
                        if (an[k] < 0) an[k] = -an[k];
                    end
                    d = d + an[0] * 128'($signed({2'b0, ex[30:1]}))
                        + an[1] * 128'($signed({2'b0, ey[30:1]}))
                        + an[2] * 128'($signed({2'b0, ez[30:1]}));
                end
                if (d < 0) vis = 1'b0;
            end
            vis_q.push_back(vis);
        endfunction

        function void check_result(bit got);
            bit want;
            if (vis_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual visible=%0b",
                         $time, got);
                errors++;
                return;
            end
            want = vis_q.pop_front();
            if (got !== want) begin
                $display("%0t: visible mismatch, expected %0b, actual %0b",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready, o_visible;
    logic [1:0] i_cmd;
    logic [2:0] i_plane_index;
    logic signed [NW-1:0] i_normal_x, i_normal_y, i_normal_z;
    logic signed [CW-1:0] i_plane_offset, i_center_x, i_center_y, i_center_z;
    logic [30:0] i_extent_x, i_extent_y, i_extent_z;

    cull_scoreboard sb;

    frustum_culling_test_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard limit: the slowest correct run is well below this.
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Gap lengths: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random fields for an item; the mode biases the values toward either
    // wide-range noise or small, realistic coordinates that separate cases.
    function automatic logic [31:0] rand_coord(bit tame);
        int r;
        if (!tame) begin
            r = $urandom_range(0, 9);
            if (r == 0) return 32'h8000_0000;
            if (r == 1) return 32'h7fff_ffff;
            return $urandom();
        end
        return 32'($signed($urandom_range(0, 200000)) - 100000);
    endfunction

    function automatic logic [15:0] rand_normal(bit tame);
        if (!tame) return 16'($urandom());
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [30:0] rand_extent(bit tame);
        if (!tame) return 31'($urandom());
        return 31'($urandom_range(0, 60000));
    endfunction

    // Presents one item and holds it until it is accepted.
    task automatic send_item(logic [1:0] cmd, logic [2:0] idx, logic [15:0] nx,
                             logic [15:0] ny, logic [15:0] nz, logic [31:0] po,
                             logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [30:0] ex, logic [30:0] ey, logic [30:0] ez);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_plane_index <= idx;
        i_normal_x <= nx;
        i_normal_y <= ny;
        i_normal_z <= nz;
        i_plane_offset <= po;
        i_center_x <= cx;
        i_center_y <= cy;
        i_center_z <= cz;
        i_extent_x <= ex;
        i_extent_y <= ey;
        i_extent_z <= ez;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(cmd, idx, nx, ny, nz, po, cx, cy, cz, ex, ey, ez);
    endtask

    task automatic send_random(logic [1:0] cmd, bit tame);
        send_item(cmd, (tame ? 3'($urandom_range(0, 5)) : 3'($urandom())),
                  rand_normal(tame), rand_normal(tame), rand_normal(tame),
                  rand_coord(tame) <<< (tame ? 6 : 0), rand_coord(tame),
                  rand_coord(tame), rand_coord(tame), rand_extent(tame),
                  rand_extent(tame), rand_extent(tame));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.vis_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: stalls at random and checks every accepted result.
    bit stall_free;
    initial begin
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!stall_free && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            if (o_valid) sb.check_result(o_visible);
        end
    end

    // Stimulus: directed corners first, then random well-formed plane sets
    // followed by bursts of tests, with a share of raw noise.
    initial begin
        int waited;
        sb = new();
        stall_free = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_LOAD;
        i_plane_index = '0;
        i_normal_x = '0;
        i_normal_y = '0;
        i_normal_z = '0;
        i_plane_offset = '0;
        i_center_x = '0;
        i_center_y = '0;
        i_center_z = '0;
        i_extent_x = '0;
        i_extent_y = '0;
        i_extent_z = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero planes after reset: every test is visible, even at extremes.
        send_item(CMD_POINT, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 0, 0, 0);
        send_item(CMD_SPHERE, 0, 0, 0, 0, 0, 32'h7fff_ffff, 0, 0, 31'h7fff_ffff, 0, 0);
        send_item(CMD_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 31'h7fff_ffff, 31'h7fff_ffff,
                  31'h7fff_ffff);
        // Plane index six and seven are ignored.
        send_item(CMD_LOAD, 6, 16'h4000, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        send_item(CMD_LOAD, 7, 16'hc000, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
        // Plane x >= 256: point on the plane touches, just behind is hidden.
        send_item(CMD_LOAD, 0, 16'h4000, 0, 0, 32'hffff_ff00, 0, 0, 0, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, 0, 0, 0, 32'h0000_0100, 0, 0, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, 0, 0, 0, 32'h0000_00ff, 0, 0, 0, 0, 0);
        // Sphere reaching the plane exactly, and one short of it.
        send_item(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 31'h100, 0, 0);
        send_item(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 31'h0ff, 0, 0);
        // Box whose half width drops its odd bit.
        send_item(CMD_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 31'h200, 0, 0);
        send_item(CMD_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 31'h1ff, 0, 0);
        // Extreme normals beyond one, and extreme offsets.
        send_item(CMD_LOAD, 5, 16'h8000, 16'h7fff, 16'h8000, 32'h7fff_ffff, 0, 0, 0,
                  0, 0, 0);
        send_item(CMD_LOAD, 4, 16'h7fff, 16'h8000, 16'h7fff, 32'h8000_0000, 0, 0, 0,
                  0, 0, 0);
        send_item(CMD_POINT, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 0, 0, 0);
        send_item(CMD_SPHERE, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 31'h7fff_ffff, 0, 0);
        send_item(CMD_BOX, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
        send_item(CMD_BOX, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 0, 31'h7fff_ffff, 1);

        // The sender holds off until every expected result has come.
        wait_drained();

        for (int rnd = 0; rnd < 70; rnd++) begin
            bit tame;
            tame = ($urandom_range(0, 9) < 8);
            stall_free = ($urandom_range(0, 5) == 0);
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (tame) begin
                    send_item(CMD_LOAD, 3'(p), rand_normal(1), rand_normal(1),
                              rand_normal(1), rand_coord(1) <<< 6, 0, 0, 0, 0, 0, 0);
                end else begin
                    send_random(CMD_LOAD, 0);
                end
            end
            for (int n = 0; n < 19; n++) begin
                send_random(2'($urandom_range(1, 3)), tame || ($urandom_range(0, 3) == 0));
            end
            if (rnd % 17 == 5) wait_drained();
        end

        wait_drained();
        stall_free = 1'b1;
        waited = 0;
        while (waited < 10) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.errors == 0 && sb.vis_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
